// ----- design/glc_pkg.sv -----
// shared types and sizing for the gemtext line classifier
`timescale 1ns / 1ps

package glc_pkg;

  localparam int BLANK_HOLD_DEPTH = 32;
  localparam int HOLD_AW = $clog2(BLANK_HOLD_DEPTH);
  localparam int HOLD_CW = $clog2(BLANK_HOLD_DEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] content_byte;
    logic       has_content;
    logic [3:0] line_kind;
    logic       line_begin;
    logic       line_end;
    logic       last_of_run;
  } res_item_t;

  typedef struct packed {
    logic load;
    logic step_go;
    logic fl_start;
    logic fl_emit;
    logic drain;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic need_flush;
    logic step_emit;
    logic fl_last;
    logic stage_v;
    logic adv;
  } dp_status_t;

endpackage

// ----- design/glc_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/glc_ctrl.sv -----
// sequencing controller for the gemtext line classifier
`timescale 1ns / 1ps

module glc_ctrl import glc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_STEP     = 2'd1;
  localparam logic [1:0] S_FL_START = 2'd2;
  localparam logic [1:0] S_FL_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (st.done) begin
          if (!st.stage_v) begin
            state_nxt = S_IDLE;
          end else if (st.adv) begin
            cmd.drain = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (st.need_flush) begin
          state_nxt = S_FL_START;
        end else if (!st.step_emit || st.adv) begin
          cmd.step_go = 1'b1;
        end
      end
      S_FL_START: begin
        cmd.fl_start = 1'b1;
        state_nxt    = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (st.adv) begin
          cmd.fl_emit = 1'b1;
          if (st.fl_last) begin
            state_nxt = S_STEP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- design/glc_dp.sv -----
// parse state, byte queue, held blank store and result registers
`timescale 1ns / 1ps

module glc_dp import glc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  input  logic       out_stall,
  output logic       out_valid,
  output res_item_t  out_data
);

  localparam logic [2:0] PH_AWAIT     = 3'd0;
  localparam logic [2:0] PH_PREFIX    = 3'd1;
  localparam logic [2:0] PH_LEAD      = 3'd2;
  localparam logic [2:0] PH_CONTENT   = 3'd3;
  localparam logic [2:0] PH_URL_AFTER = 3'd4;
  localparam logic [2:0] PH_PRE_START = 3'd5;
  localparam logic [2:0] PH_PRE_BODY  = 3'd6;

  localparam logic [3:0] K_PARA  = 4'd0;
  localparam logic [3:0] K_H1    = 4'd1;
  localparam logic [3:0] K_H2    = 4'd2;
  localparam logic [3:0] K_H3    = 4'd3;
  localparam logic [3:0] K_LIST  = 4'd4;
  localparam logic [3:0] K_QUOTE = 4'd5;
  localparam logic [3:0] K_URL   = 4'd6;
  localparam logic [3:0] K_DESC  = 4'd7;
  localparam logic [3:0] K_PRE   = 4'd8;
  localparam logic [3:0] K_END   = 4'd9;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_TICK  = 8'h60;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // parse state
  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         kind_r, kind_nxt;
  logic               started_r, started_nxt;
  logic [7:0]         la_r [3];
  logic [7:0]         la_nxt [3];
  logic [1:0]         la_cnt_r, la_cnt_nxt;
  logic [HOLD_CW-1:0] held_cnt_r, held_cnt_nxt;
  logic [1:0]         fence_r, fence_nxt;
  // bytes still to run through the current phase
  logic [7:0]         q_r [4];
  logic [7:0]         q_nxt [4];
  logic [2:0]         q_cnt_r, q_cnt_nxt;
  logic               eot_r, eot_nxt;
  logic [HOLD_AW-1:0] fl_idx_r, fl_idx_nxt;
  // one result is staged so the last one of an item can be marked
  res_item_t          stage_r, stage_nxt;
  logic               stage_v_r, stage_v_nxt;
  res_item_t          out_r, out_nxt;
  logic               out_v_r, out_v_nxt;

  logic [7:0]         b;
  logic               has_b;
  logic [7:0]         q_pop [4];
  logic [7:0]         rep_q [4];
  logic [2:0]         rep_cnt;
  logic [7:0]         fen_q [4];
  logic [2:0]         fen_cnt;
  logic               m_h1, m_url, m_h2, m_pre, m_h3;
  logic               held_nz, held_full, fl_last, adv;

  // step plan
  logic [2:0]         p_phase;
  logic [3:0]         p_kind;
  logic [1:0]         p_fence;
  logic [7:0]         p_la [3];
  logic [1:0]         p_la_cnt;
  logic [7:0]         p_q [4];
  logic [2:0]         p_q_cnt;
  logic               p_unstart, p_emit, p_hold, p_held_clr, p_flush, p_reset, p_eot_clr;
  res_item_t          p_res, fl_res;

  logic               ram_we, ram_re;
  logic [HOLD_AW-1:0] ram_raddr;
  logic [0:0]         ram_wdata, ram_rdata;

  assign b         = q_r[0];
  assign has_b     = (q_cnt_r != 3'd0);
  assign held_nz   = (held_cnt_r != '0);
  assign held_full = (held_cnt_r == HOLD_CW'(BLANK_HOLD_DEPTH));
  assign fl_last   = ((HOLD_CW'(fl_idx_r) + HOLD_CW'(1)) == held_cnt_r);
  assign adv       = !out_v_r || !out_stall;

  assign m_h1  = (la_cnt_r == 2'd1) && (la_r[0] == CH_HASH) && is_blank(b);
  assign m_url = (la_cnt_r == 2'd1) && (la_r[0] == CH_EQ) && (b == CH_GT);
  assign m_h2  = (la_cnt_r == 2'd2) && (la_r[0] == CH_HASH) && (la_r[1] == CH_HASH)
                 && is_blank(b);
  assign m_pre = (la_cnt_r == 2'd2) && (la_r[0] == CH_TICK) && (la_r[1] == CH_TICK)
                 && (b == CH_TICK);
  assign m_h3  = (la_cnt_r == 2'd3) && (la_r[0] == CH_HASH) && (la_r[1] == CH_HASH)
                 && (la_r[2] == CH_HASH) && is_blank(b);

  // queue shapes: pop, paragraph replay, fence replay
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_pop[i] = q_r[i + 1];
    end
    q_pop[3] = 8'h00;

    rep_q = '{default: 8'h00};
    for (int i = 0; i < 3; i++) begin
      if (i < int'(la_cnt_r)) begin
        rep_q[i] = la_r[i];
      end
    end
    if (has_b) begin
      rep_q[la_cnt_r] = b;
    end
    rep_cnt = {1'b0, la_cnt_r} + {2'b00, has_b};

    fen_q = '{default: 8'h00};
    for (int i = 0; i < 2; i++) begin
      if (i < int'(fence_r)) begin
        fen_q[i] = CH_TICK;
      end
    end
    if (has_b) begin
      fen_q[fence_r] = b;
    end
    fen_cnt = {1'b0, fence_r} + {2'b00, has_b};
  end

  // what one step does with the head byte, or with end of text once the queue is empty
  always_comb begin
    p_phase    = phase_r;
    p_kind     = kind_r;
    p_fence    = fence_r;
    p_la       = la_r;
    p_la_cnt   = la_cnt_r;
    p_q        = q_r;
    p_q_cnt    = q_cnt_r;
    p_unstart  = 1'b0;
    p_emit     = 1'b0;
    p_hold     = 1'b0;
    p_held_clr = 1'b0;
    p_flush    = 1'b0;
    p_reset    = 1'b0;
    p_eot_clr  = 1'b0;
    p_res      = '{content_byte: 8'h00, has_content: 1'b0, line_kind: kind_r,
                   line_begin: !started_r, line_end: 1'b0, last_of_run: 1'b0};

    if (has_b) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if ((b == CH_NL) || ((la_cnt_r == 2'd3) && !m_h3)) begin
            p_q        = rep_q;
            p_q_cnt    = rep_cnt;
            p_kind     = K_PARA;
            p_unstart  = 1'b1;
            p_held_clr = 1'b1;
            p_fence    = 2'd0;
            p_phase    = PH_CONTENT;
            p_la_cnt   = 2'd0;
          end else begin
            p_q     = q_pop;
            p_q_cnt = q_cnt_r - 3'd1;
            if (m_h1 || m_url || m_h2 || m_pre || m_h3) begin
              p_la_cnt   = 2'd0;
              p_unstart  = 1'b1;
              p_held_clr = 1'b1;
              p_fence    = 2'd0;
              p_phase    = PH_LEAD;
              if (m_h1) begin
                p_kind = K_H1;
              end else if (m_url) begin
                p_kind = K_URL;
              end else if (m_h2) begin
                p_kind = K_H2;
              end else if (m_pre) begin
                p_kind = K_PRE;
              end else begin
                p_kind = K_H3;
              end
            end else begin
              p_la[la_cnt_r] = b;
              p_la_cnt       = la_cnt_r + 2'd1;
            end
          end
        end
        PH_LEAD: begin
          if (is_blank(b)) begin
            p_q     = q_pop;
            p_q_cnt = q_cnt_r - 3'd1;
          end else if (kind_r == K_PRE) begin
            p_phase = PH_PRE_START;
            p_fence = 2'd0;
          end else begin
            p_phase = PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          if (b == CH_NL) begin
            p_emit          = 1'b1;
            p_res.line_end  = 1'b1;
            p_held_clr      = 1'b1;
            p_phase         = PH_AWAIT;
            p_q             = q_pop;
            p_q_cnt         = q_cnt_r - 3'd1;
          end else if (is_blank(b)) begin
            if (kind_r == K_URL) begin
              // a blank ends the url, the rest may become a description
              p_emit         = 1'b1;
              p_res.line_end = 1'b1;
              p_held_clr     = 1'b1;
              p_phase        = PH_URL_AFTER;
              p_q            = q_pop;
              p_q_cnt        = q_cnt_r - 3'd1;
            end else if (held_full) begin
              p_flush = 1'b1;
            end else begin
              p_hold  = 1'b1;
              p_q     = q_pop;
              p_q_cnt = q_cnt_r - 3'd1;
            end
          end else if (held_nz) begin
            p_flush = 1'b1;
          end else begin
            p_emit             = 1'b1;
            p_res.content_byte = b;
            p_res.has_content  = 1'b1;
            p_q                = q_pop;
            p_q_cnt            = q_cnt_r - 3'd1;
          end
        end
        PH_URL_AFTER: begin
          if (is_blank(b)) begin
            p_q     = q_pop;
            p_q_cnt = q_cnt_r - 3'd1;
          end else if (b == CH_NL) begin
            p_phase = PH_AWAIT;
            p_q     = q_pop;
            p_q_cnt = q_cnt_r - 3'd1;
          end else begin
            p_kind     = K_DESC;
            p_unstart  = 1'b1;
            p_held_clr = 1'b1;
            p_fence    = 2'd0;
            p_phase    = PH_CONTENT;
          end
        end
        PH_PRE_START: begin
          if (b == CH_TICK) begin
            p_q     = q_pop;
            p_q_cnt = q_cnt_r - 3'd1;
            if (fence_r >= 2'd2) begin
              p_fence        = 2'd0;
              p_emit         = 1'b1;
              p_res.line_end = 1'b1;
              p_held_clr     = 1'b1;
              p_phase        = PH_AWAIT;
            end else begin
              p_fence = fence_r + 2'd1;
            end
          end else begin
            // partial fence turns back into body bytes
            p_q     = fen_q;
            p_q_cnt = fen_cnt;
            p_fence = 2'd0;
            p_phase = PH_PRE_BODY;
          end
        end
        PH_PRE_BODY: begin
          if (is_blank(b)) begin
            if (held_full) begin
              p_flush = 1'b1;
            end else begin
              p_hold  = 1'b1;
              p_q     = q_pop;
              p_q_cnt = q_cnt_r - 3'd1;
            end
          end else if (held_nz) begin
            p_flush = 1'b1;
          end else begin
            p_emit             = 1'b1;
            p_res.content_byte = b;
            p_res.has_content  = 1'b1;
            p_q                = q_pop;
            p_q_cnt            = q_cnt_r - 3'd1;
            if (b == CH_NL) begin
              p_phase = PH_PRE_START;
              p_fence = 2'd0;
            end
          end
        end
        default: begin
          p_q     = q_pop;
          p_q_cnt = q_cnt_r - 3'd1;
          p_phase = PH_AWAIT;
          if (b == CH_GT || b == CH_STAR) begin
            p_kind     = (b == CH_GT) ? K_QUOTE : K_LIST;
            p_unstart  = 1'b1;
            p_held_clr = 1'b1;
            p_fence    = 2'd0;
            p_phase    = PH_LEAD;
          end else if (!is_blank(b) && b != CH_NL) begin
            p_la[0]  = b;
            p_la_cnt = 2'd1;
            p_phase  = PH_PREFIX;
          end
        end
      endcase
    end else if (eot_r) begin
      unique case (phase_r) inside
        PH_PREFIX: begin
          p_q        = rep_q;
          p_q_cnt    = rep_cnt;
          p_kind     = K_PARA;
          p_unstart  = 1'b1;
          p_held_clr = 1'b1;
          p_fence    = 2'd0;
          p_phase    = PH_CONTENT;
          p_la_cnt   = 2'd0;
        end
        PH_PRE_START: begin
          p_q     = fen_q;
          p_q_cnt = fen_cnt;
          p_fence = 2'd0;
          p_phase = PH_PRE_BODY;
        end
        PH_LEAD, PH_CONTENT, PH_PRE_BODY: begin
          p_emit         = 1'b1;
          p_res.line_end = 1'b1;
          p_held_clr     = 1'b1;
          p_phase        = PH_AWAIT;
        end
        default: begin
          p_emit    = 1'b1;
          p_res     = '{content_byte: 8'h00, has_content: 1'b0, line_kind: K_END,
                        line_begin: 1'b0, line_end: 1'b0, last_of_run: 1'b0};
          p_reset   = 1'b1;
          p_eot_clr = 1'b1;
        end
      endcase
    end
  end

  assign fl_res = '{content_byte: ram_rdata[0] ? CH_TAB : CH_SPACE, has_content: 1'b1,
                    line_kind: kind_r, line_begin: !started_r, line_end: 1'b0,
                    last_of_run: 1'b0};

  // held blanks are spaces or tabs, one bit each
  assign ram_we    = cmd.step_go && p_hold;
  assign ram_wdata = (b == CH_TAB);
  assign ram_re    = cmd.fl_start || (cmd.fl_emit && !fl_last);
  assign ram_raddr = cmd.fl_start ? '0 : (fl_idx_r + HOLD_AW'(1));

  glc_ram #(
    .WIDTH (1),
    .DEPTH (BLANK_HOLD_DEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (held_cnt_r[HOLD_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    started_nxt  = started_r;
    la_nxt       = la_r;
    la_cnt_nxt   = la_cnt_r;
    held_cnt_nxt = held_cnt_r;
    fence_nxt    = fence_r;
    q_nxt        = q_r;
    q_cnt_nxt    = q_cnt_r;
    eot_nxt      = eot_r;
    fl_idx_nxt   = fl_idx_r;
    stage_nxt    = stage_r;
    stage_v_nxt  = stage_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_stall ? out_v_r : 1'b0;

    if (cmd.load) begin
      q_nxt[0]  = in_data.text_byte;
      q_cnt_nxt = in_data.end_of_text ? 3'd0 : 3'd1;
      eot_nxt   = in_data.end_of_text;
    end

    if (cmd.step_go) begin
      phase_nxt  = p_phase;
      kind_nxt   = p_kind;
      fence_nxt  = p_fence;
      la_nxt     = p_la;
      la_cnt_nxt = p_la_cnt;
      q_nxt      = p_q;
      q_cnt_nxt  = p_q_cnt;
      if (p_eot_clr) begin
        eot_nxt = 1'b0;
      end
      if (p_emit) begin
        started_nxt = !p_res.line_end;
      end
      if (p_unstart) begin
        started_nxt = 1'b0;
      end
      if (p_held_clr) begin
        held_cnt_nxt = '0;
      end
      if (p_hold) begin
        held_cnt_nxt = held_cnt_r + HOLD_CW'(1);
      end
      if (p_reset) begin
        phase_nxt    = PH_AWAIT;
        kind_nxt     = K_PARA;
        started_nxt  = 1'b0;
        la_cnt_nxt   = 2'd0;
        held_cnt_nxt = '0;
        fence_nxt    = 2'd0;
      end
    end

    if (cmd.fl_start) begin
      fl_idx_nxt = '0;
    end
    if (cmd.fl_emit) begin
      started_nxt = 1'b1;
      if (fl_last) begin
        held_cnt_nxt = '0;
      end else begin
        fl_idx_nxt = fl_idx_r + HOLD_AW'(1);
      end
    end

    // staged result moves out when a newer one arrives or the item finishes
    if ((cmd.step_go && p_emit) || cmd.fl_emit) begin
      stage_nxt   = cmd.fl_emit ? fl_res : p_res;
      stage_v_nxt = 1'b1;
      if (stage_v_r) begin
        out_nxt             = stage_r;
        out_nxt.last_of_run = 1'b0;
        out_v_nxt           = 1'b1;
      end
    end
    if (cmd.drain) begin
      out_nxt             = stage_r;
      out_nxt.last_of_run = 1'b1;
      out_v_nxt           = 1'b1;
      stage_v_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    la_r     <= la_nxt;
    q_r      <= q_nxt;
    fl_idx_r <= fl_idx_nxt;
    stage_r  <= stage_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      phase_r    <= PH_AWAIT;
      kind_r     <= K_PARA;
      started_r  <= 1'b0;
      la_cnt_r   <= 2'd0;
      held_cnt_r <= '0;
      fence_r    <= 2'd0;
      q_cnt_r    <= 3'd0;
      eot_r      <= 1'b0;
      stage_v_r  <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      started_r  <= started_nxt;
      la_cnt_r   <= la_cnt_nxt;
      held_cnt_r <= held_cnt_nxt;
      fence_r    <= fence_nxt;
      q_cnt_r    <= q_cnt_nxt;
      eot_r      <= eot_nxt;
      stage_v_r  <= stage_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  assign st.done       = !has_b && !eot_r;
  assign st.need_flush = p_flush;
  assign st.step_emit  = p_emit;
  assign st.fl_last    = fl_last;
  assign st.stage_v    = stage_v_r;
  assign st.adv        = adv;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- design/gemtext_line_classifier.sv -----
// top level of the gemtext line classifier
`timescale 1ns / 1ps

// Takes a gemtext document one byte per item and returns its content bytes, each tagged
// with its line kind, plus line begin/end marks and a closing end-of-text result.
// An item is taken only when the block is idle. Each item goes through a load, then
// its parse steps, then a closing step that releases its last result, if any. A change
// of line phase that looks at the byte again (prefix replay, lead-in to content, url to
// description, fence replay) takes a further step, and so does each replayed prefix
// or fence byte; end of text settles each pending action in a step of its own before
// the step for its end result. Trailing blanks sit in a one-bit-per-entry ram; a flush
// first sees the need, then starts its single registered read port, then sends the
// blanks out in turn. A stalled output holds back every step that has a result to pass
// on. The last result of every item stays in a
// one-deep staging register until the item is finished, so last_of_run can be marked,
// and a finished result waits in the output register while the next item is taken.
// The blank store needs no clearing pass after reset: entries are only read below the
// count of blanks held.

module gemtext_line_classifier import glc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // input items
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result items
  output logic      out_valid,
  input  logic      out_stall,
  output res_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer: load, step through queued bytes, flush held blanks, drain
  glc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // parse state, blank store and the result registers
  glc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a step that produces a result only fires when the output side can move
  a_step_emit_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_go && st.step_emit) |-> st.adv)
    else $error("step result issued while output blocked");

  // a flushed blank only goes out when the output side can move
  a_flush_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fl_emit |-> st.adv)
    else $error("flush result issued while output blocked");

  // a new item is taken only once the previous one is fully worked off
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (st.done && !st.stage_v))
    else $error("item accepted with work pending");

  // a flush starts only when a step asked for it
  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fl_start |-> st.need_flush)
    else $error("flush started without held blanks to release");
`endif

endmodule

// ----- sim/tb_gemtext_line_classifier.sv -----
// testbench for the gemtext line classifier: byte stream in, tagged content bytes checked out
`timescale 1ns / 1ps

module tb_gemtext_line_classifier;
  import glc_pkg::*;

  // line kind codes as carried in line_kind
  localparam logic [3:0] KIND_PARA = 4'd0, KIND_H1 = 4'd1, KIND_H2 = 4'd2, KIND_H3 = 4'd3;
  localparam logic [3:0] KIND_LIST = 4'd4, KIND_QUOTE = 4'd5, KIND_URL = 4'd6;
  localparam logic [3:0] KIND_DESC = 4'd7, KIND_PRE = 4'd8, KIND_END = 4'd9;

  // characters the parser cares about
  localparam logic [7:0] CH_SPACE = 8'h20, CH_TAB = 8'h09, CH_NL = 8'h0a, CH_HASH = 8'h23;
  localparam logic [7:0] CH_EQ = 8'h3d, CH_GT = 8'h3e, CH_STAR = 8'h2a, CH_TICK = 8'h60;

  localparam int MAX_GAP      = 9;
  localparam int RANDOM_ITEMS = 290;
  localparam int MAX_RES      = 40;
  // worst quiet stretch is a long blank flush under full output stall, well below this
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 60;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    ST_IDLE, ST_MARKER, ST_LEADIN, ST_TEXT, ST_URL_GAP, ST_FENCE, ST_RAW
  } parse_st_t;

  // one row of the directed table; typed rows carry their single expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    res_item_t  want;
  } stim_row_t;

  localparam res_item_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [25] = '{
    // end of text right after reset gives just the end marker
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, KIND_END, 1'b0, 1'b0, 1'b1}},
    '{CH_SPACE, 1'b0, 1'b0, NO_RESULT},  // leading blank skipped
    '{CH_HASH, 1'b0, 1'b0, NO_RESULT},
    '{CH_TAB, 1'b0, 1'b0, NO_RESULT},    // heading marker with tab
    // heading with no text: one empty begin+end result
    '{CH_NL, 1'b0, 1'b1, '{8'h00, 1'b0, KIND_H1, 1'b1, 1'b1, 1'b1}},
    '{CH_EQ, 1'b0, 1'b0, NO_RESULT},
    '{CH_GT, 1'b0, 1'b0, NO_RESULT},
    '{8'h75, 1'b0, 1'b0, NO_RESULT},     // 'u' url text
    '{CH_SPACE, 1'b0, 1'b0, NO_RESULT},  // blank ends the url
    '{8'h64, 1'b0, 1'b0, NO_RESULT},     // 'd' starts the description
    '{CH_NL, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},   // opening fence
    '{CH_NL, 1'b0, 1'b0, NO_RESULT},     // newline is raw content
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{CH_NL, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},
    '{CH_TICK, 1'b0, 1'b0, NO_RESULT},   // closing fence
    '{8'h00, 1'b0, 1'b0, NO_RESULT},     // text right after the fence, pending prefix
    '{8'hff, 1'b1, 1'b0, NO_RESULT},     // end of text replays the prefix
    '{CH_GT, 1'b0, 1'b0, NO_RESULT},     // new document, quote
    '{CH_STAR, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  res_item_t out_data;

  // predictor state
  parse_st_t  ps;
  logic [3:0] kind_q;
  logic [7:0] look [3];
  int         look_n;
  logic [7:0] held [BLANK_HOLD_DEPTH];
  int         held_n;
  int         fence_n;
  bit         in_line;

  res_item_t  item_results [$];    // results of the item just accepted
  res_item_t  awaited_results [$]; // results still to come out of the block
  in_item_t   doc_q [$];           // bytes of the document being sent

  int mismatches  = 0;
  int idle_cycles = 0;
  bit in_burst    = 1'b0;
  bit out_burst   = 1'b0;

  gemtext_line_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // one result of the current line; begin is set on the first one
  function automatic void emit(bit has, logic [7:0] c, bit fin);
    res_item_t r;
    r.content_byte = has ? c : 8'h00;
    r.has_content  = has;
    r.line_kind    = kind_q;
    r.line_begin   = !in_line;
    r.line_end     = fin;
    r.last_of_run  = 1'b0;
    if (item_results.size() < MAX_RES) item_results.push_back(r);
    in_line = !fin;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) emit(1'b1, held[i], 1'b0);
    held_n = 0;
  endfunction

  // a full hold buffer goes out as content before the new blank is held
  function automatic void hold_blank(logic [7:0] c);
    if (held_n >= BLANK_HOLD_DEPTH) flush_held();
    held[held_n] = c;
    held_n++;
  endfunction

  // trailing blanks are dropped at line end
  function automatic void close_line();
    held_n = 0;
    emit(1'b0, 8'h00, 1'b1);
  endfunction

  function automatic void start_kind(logic [3:0] k);
    kind_q  = k;
    in_line = 1'b0;
    held_n  = 0;
    fence_n = 0;
    ps      = ST_LEADIN;
  endfunction

  function automatic void on_text(logic [7:0] c);
    if (c == CH_NL) begin
      close_line();
      ps = ST_IDLE;
    end else if (is_blank(c)) begin
      if (kind_q == KIND_URL) begin
        close_line();
        ps = ST_URL_GAP;
      end else begin
        hold_blank(c);
      end
    end else begin
      flush_held();
      emit(1'b1, c, 1'b0);
    end
  endfunction

  // preformatted body: newlines are content and flush held blanks
  function automatic void on_raw(logic [7:0] c);
    if (is_blank(c)) begin
      hold_blank(c);
    end else begin
      flush_held();
      emit(1'b1, c, 1'b0);
      if (c == CH_NL) begin
        ps      = ST_FENCE;
        fence_n = 0;
      end
    end
  endfunction

  // backticks of a fence that did not complete become raw content
  function automatic void replay_ticks();
    int k;
    k       = fence_n;
    fence_n = 0;
    repeat (k) on_raw(CH_TICK);
  endfunction

  function automatic void on_fence(logic [7:0] c);
    if (c == CH_TICK) begin
      if (fence_n >= 2) begin
        fence_n = 0;
        close_line();
        ps = ST_IDLE;
      end else begin
        fence_n++;
      end
    end else begin
      ps = ST_RAW;
      replay_ticks();
      on_raw(c);
    end
  endfunction

  // no marker matched: the held prefix bytes become paragraph text
  function automatic void replay_para();
    int n;
    n      = look_n;
    look_n = 0;
    start_kind(KIND_PARA);
    ps = ST_TEXT;
    for (int i = 0; i < n; i++) on_text(look[i]);
  endfunction

  function automatic void on_marker(logic [7:0] c);
    int n;
    n = look_n;
    if (c == CH_NL) begin
      replay_para();
      on_text(c);
    end else if (n == 1 && look[0] == CH_HASH && is_blank(c)) begin
      look_n = 0;
      start_kind(KIND_H1);
    end else if (n == 1 && look[0] == CH_EQ && c == CH_GT) begin
      look_n = 0;
      start_kind(KIND_URL);
    end else if (n == 2 && look[0] == CH_HASH && look[1] == CH_HASH && is_blank(c)) begin
      look_n = 0;
      start_kind(KIND_H2);
    end else if (n == 2 && look[0] == CH_TICK && look[1] == CH_TICK && c == CH_TICK) begin
      look_n = 0;
      start_kind(KIND_PRE);
    end else if (n == 3 && look[0] == CH_HASH && look[1] == CH_HASH && look[2] == CH_HASH
                 && is_blank(c)) begin
      look_n = 0;
      start_kind(KIND_H3);
    end else if (n == 3) begin
      replay_para();
      on_text(c);
    end else begin
      look[n] = c;
      look_n  = n + 1;
    end
  endfunction

  function automatic void on_idle(logic [7:0] c);
    if (is_blank(c) || c == CH_NL) return;
    if (c == CH_GT) begin
      start_kind(KIND_QUOTE);
    end else if (c == CH_STAR) begin
      start_kind(KIND_LIST);
    end else begin
      look[0] = c;
      look_n  = 1;
      ps      = ST_MARKER;
    end
  endfunction

  function automatic void on_leadin(logic [7:0] c);
    if (is_blank(c)) return;
    if (kind_q == KIND_PRE) begin
      ps      = ST_FENCE;
      fence_n = 0;
      on_fence(c);
    end else begin
      ps = ST_TEXT;
      on_text(c);
    end
  endfunction

  function automatic void on_url_gap(logic [7:0] c);
    if (is_blank(c)) return;
    if (c == CH_NL) begin
      ps = ST_IDLE;
    end else begin
      start_kind(KIND_DESC);
      ps = ST_TEXT;
      on_text(c);
    end
  endfunction

  function automatic void clear_model();
    ps      = ST_IDLE;
    kind_q  = KIND_PARA;
    look_n  = 0;
    held_n  = 0;
    fence_n = 0;
    in_line = 1'b0;
    for (int i = 0; i < 3; i++) look[i] = 8'h00;
    for (int i = 0; i < BLANK_HOLD_DEPTH; i++) held[i] = 8'h00;
  endfunction

  // end of document: settle whatever is pending, then the end marker
  function automatic void on_end();
    res_item_t r;
    case (ps)
      ST_MARKER: begin
        replay_para();
        close_line();
      end
      ST_LEADIN, ST_TEXT, ST_RAW: close_line();
      ST_FENCE: begin
        replay_ticks();
        close_line();
      end
      default: ;
    endcase
    r           = '0;
    r.line_kind = KIND_END;
    if (item_results.size() < MAX_RES) item_results.push_back(r);
    clear_model();
  endfunction

  function automatic void classify_item(in_item_t it);
    res_item_t r;
    item_results.delete();
    if (it.end_of_text) begin
      on_end();
    end else begin
      case (ps)
        ST_MARKER:  on_marker(it.text_byte);
        ST_LEADIN:  on_leadin(it.text_byte);
        ST_TEXT:    on_text(it.text_byte);
        ST_URL_GAP: on_url_gap(it.text_byte);
        ST_FENCE:   on_fence(it.text_byte);
        ST_RAW:     on_raw(it.text_byte);
        default:    on_idle(it.text_byte);
      endcase
    end
    if (item_results.size() > 0) begin
      r             = item_results.pop_back();
      r.last_of_run = 1'b1;
      item_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- document builder

  // mostly printable text, now and then any byte at all
  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  function automatic void put_char(logic [7:0] c);
    in_item_t it;
    it.text_byte   = c;
    it.end_of_text = 1'b0;
    doc_q.push_back(it);
  endfunction

  function automatic void put_text(int n);
    repeat (n) put_char(text_char());
  endfunction

  function automatic void put_blanks(int n);
    repeat (n) put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // a document of mostly well-formed lines with random content, some noise and broken
  // markers, closed by end of text (sometimes with a marker or fence still pending)
  function automatic void build_document();
    int       lines;
    int       sel;
    bit       open_end;
    in_item_t it;
    lines    = $urandom_range(1, 6);
    open_end = 1'b0;
    for (int l = 0; l < lines && !open_end; l++) begin
      if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 3));
      sel = $urandom_range(0, 11);
      case (sel)
        0: put_text($urandom_range(1, 8));
        1, 2, 3: begin
          repeat (sel) put_char(CH_HASH);
          put_blanks($urandom_range(1, 2));
          put_text($urandom_range(0, 8));
        end
        4, 5: begin
          put_char(sel == 4 ? CH_STAR : CH_GT);
          put_blanks($urandom_range(0, 2));
          put_text($urandom_range(0, 8));
        end
        6: begin
          put_char(CH_EQ);
          put_char(CH_GT);
          put_blanks($urandom_range(0, 2));
          put_text($urandom_range(1, 10));
          if ($urandom_range(0, 2) != 0) begin
            put_blanks($urandom_range(1, 3));
            put_text($urandom_range(1, 8));
          end
        end
        7: begin
          repeat (3) put_char(CH_TICK);
          if ($urandom_range(0, 1)) put_text($urandom_range(1, 4));
          put_char(CH_NL);
          repeat ($urandom_range(0, 3)) begin
            // body lines, some starting like a fence that never completes
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) put_char(CH_TICK);
            put_text($urandom_range(0, 6));
            put_blanks($urandom_range(0, 3));
            put_text($urandom_range(0, 3));
            put_char(CH_NL);
          end
          if ($urandom_range(0, 4) == 0) begin
            // block left open at end of text
            open_end = 1'b1;
            if ($urandom_range(0, 1)) repeat ($urandom_range(1, 2)) put_char(CH_TICK);
            else put_blanks($urandom_range(1, 3));
          end else begin
            repeat (3) put_char(CH_TICK);
            if ($urandom_range(0, 2) == 0) put_text($urandom_range(1, 4));
          end
        end
        8: put_blanks($urandom_range(0, 3));
        9: repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
        10: begin
          // marker start that goes wrong
          case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 3)) put_char(CH_HASH);
            1: put_char(CH_EQ);
            2: repeat ($urandom_range(1, 2)) put_char(CH_TICK);
            default: repeat (4) put_char(CH_HASH);
          endcase
          put_text($urandom_range(0, 4));
        end
        default: begin
          // blank run around the hold depth
          put_text($urandom_range(1, 3));
          put_blanks($urandom_range(BLANK_HOLD_DEPTH - 4, BLANK_HOLD_DEPTH + 8));
          if ($urandom_range(0, 1)) put_text($urandom_range(1, 3));
        end
      endcase
      if (!open_end) begin
        if ($urandom_range(0, 2) == 0) put_blanks($urandom_range(1, 3));
        if (l != lines - 1 || $urandom_range(0, 3) != 0) put_char(CH_NL);
      end
    end
    if (!open_end && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: put_char(CH_HASH);
        1: repeat (2) put_char(CH_HASH);
        2: put_char(CH_EQ);
        default: repeat (2) put_char(CH_TICK);
      endcase
    end
    it.text_byte   = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    doc_q.push_back(it);
  endfunction

  // ---------------------------------------------------------------- drivers

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(in_item_t it, bit typed, res_item_t want);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    classify_item(it);
    if (typed) awaited_results.push_back(want);
    else foreach (item_results[i]) awaited_results.push_back(item_results[i]);
    @(negedge clk);
  endtask

  // result side: random stall before each result, with runs of no stall
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(res_item_t got);
    res_item_t want;
    if (awaited_results.size() == 0) begin
      $error("result %h arrived with nothing expected", got);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("content_byte", want.content_byte, got.content_byte);
      check_field("has_content", 8'(want.has_content), 8'(got.has_content));
      check_field("line_kind", 8'(want.line_kind), 8'(got.line_kind));
      check_field("line_begin", 8'(want.line_begin), 8'(got.line_begin));
      check_field("line_end", 8'(want.line_end), 8'(got.line_end));
      check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gemtext_line_classifier: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    in_item_t it;
    int       sent;
    clear_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < $size(DIRECTED); i++) begin
      it.text_byte   = DIRECTED[i].ch;
      it.end_of_text = DIRECTED[i].eot;
      send_item(it, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random documents, some sent back to back
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_document();
      in_burst = ($urandom_range(0, 3) == 0);
      while (doc_q.size() != 0) begin
        it = doc_q.pop_front();
        send_item(it, 1'b0, NO_RESULT);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then a tail to catch stray results
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("gemtext_line_classifier: match");
    end else begin
      $display("gemtext_line_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/glc_pkg.sv
design/glc_ram.sv
design/glc_ctrl.sv
design/glc_dp.sv
design/gemtext_line_classifier.sv
sim/tb_gemtext_line_classifier.sv
